>>> sv/brr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brr_pkg
// Shared types and opcode constants for the branch resolver.
// ----------------------------------------------------------------------------
package brr_pkg;

    localparam int DataW = 64;
    localparam int InstW = 32;
    localparam int RegW  = 5;

    typedef logic [DataW-1:0] t_data;
    typedef logic [InstW-1:0] t_inst;
    typedef logic [RegW-1:0]  t_reg_idx;
    typedef logic [6:0]       t_opcode;
    typedef logic [2:0]       t_funct3;

    localparam t_opcode OPC_BRANCH = 7'h63;
    localparam t_opcode OPC_JAL    = 7'h6f;
    localparam t_opcode OPC_JALR   = 7'h67;

    localparam t_funct3 F3_BEQ  = 3'd0;
    localparam t_funct3 F3_BNE  = 3'd1;
    localparam t_funct3 F3_BLT  = 3'd4;
    localparam t_funct3 F3_BGE  = 3'd5;
    localparam t_funct3 F3_BLTU = 3'd6;
    localparam t_funct3 F3_BGEU = 3'd7;
    localparam t_funct3 F3_JALR = 3'd0;

    localparam t_reg_idx REG_ZERO = 5'd0;

    typedef struct packed {
        t_inst    instruction;
        t_data    pc_value;
        t_data    rs1_file_value;
        t_data    rs2_file_value;
        logic     exe_fwd_valid;
        t_reg_idx exe_fwd_reg;
        t_data    exe_fwd_value;
        logic     wb_fwd_valid;
        t_reg_idx wb_fwd_reg;
        t_data    wb_fwd_value;
    } t_req;

    typedef struct packed {
        logic  is_control;
        logic  resolved;
        logic  taken;
        t_data target;
    } t_rsp;

endpackage

>>> sv/brr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brr_if
// Valid/ready channels for branch requests and resolution results.
// ----------------------------------------------------------------------------
interface brr_req_if;
    logic          valid;
    logic          ready;
    brr_pkg::t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface brr_rsp_if;
    logic          valid;
    logic          ready;
    brr_pkg::t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/riscv_branch_resolver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// riscv_branch_resolver
// Resolves RV32/RV64 branch, JAL and JALR outcome and next pc.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request per handshake: instruction word, pc, the two
//   register file values and one bypass slot each from EXE and WB. o_rsp
//   carries one result per request: is_control, resolved, taken, target.
//   A request passes from accept to result valid through one input
//   register stage, then decode, bypass select, compare and four adders,
//   then the result register. Throughput is one request per cycle while
//   ready is high. A stalled o_rsp holds its result; the input stage still
//   takes a new request while it is empty, so ready drops only when both
//   stages are full and the receiver stalls. Reset empties both stages; no
//   result is shown until a request enters. XLEN sets the operand width;
//   target is zero-extended to 64 bits.
// ----------------------------------------------------------------------------
module riscv_branch_resolver #(
    parameter int XLEN = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    brr_req_if.sink    i_req,
    brr_rsp_if.source  o_rsp
);

    logic          r_s1_valid;
    logic          n_s1_valid;
    brr_pkg::t_req r_s1_req;
    logic          r_s2_valid;
    logic          n_s2_valid;
    brr_pkg::t_rsp r_s2_rsp;
    brr_pkg::t_rsp n_s2_rsp;
    logic          s1_open;
    logic          s2_open;

    assign s2_open = !r_s2_valid || o_rsp.ready;
    assign s1_open = !r_s1_valid || s2_open;

    assign i_req.ready   = s1_open;
    assign o_rsp.valid   = r_s2_valid;
    assign o_rsp.payload = r_s2_rsp;

    brr_resolve #(.XLEN(XLEN)) u_resolve (
        .i_req (r_s1_req),
        .o_rsp (n_s2_rsp)
    );

    always_comb begin
        n_s1_valid = s1_open ? i_req.valid : r_s1_valid;
        n_s2_valid = s2_open ? r_s1_valid : r_s2_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= n_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_open && i_req.valid) begin
            r_s1_req <= i_req.payload;
        end
        if (s2_open && r_s1_valid) begin
            r_s2_rsp <= n_s2_rsp;
        end
    end

endmodule

>>> sv/brr_operand.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brr_operand
// Source operand select: x0, then EXE bypass, then WB bypass, then file.
// ----------------------------------------------------------------------------
module brr_operand #(
    parameter int XLEN = 64
) (
    input  brr_pkg::t_reg_idx i_src,
    input  brr_pkg::t_data    i_file_value,
    input  brr_pkg::t_req     i_req,
    output logic [XLEN-1:0]   o_value
);

    always_comb begin
        if (i_src == brr_pkg::REG_ZERO) begin
            o_value = '0;
        end else if (i_req.exe_fwd_valid && i_req.exe_fwd_reg == i_src) begin
            o_value = i_req.exe_fwd_value[XLEN-1:0];
        end else if (i_req.wb_fwd_valid && i_req.wb_fwd_reg == i_src) begin
            o_value = i_req.wb_fwd_value[XLEN-1:0];
        end else begin
            o_value = i_file_value[XLEN-1:0];
        end
    end

endmodule

>>> sv/brr_resolve.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brr_resolve
// Decode, operand compare and target adders for one control instruction.
// ----------------------------------------------------------------------------
module brr_resolve #(
    parameter int XLEN = 64
) (
    input  brr_pkg::t_req i_req,
    output brr_pkg::t_rsp o_rsp
);

    brr_pkg::t_inst     inst;
    brr_pkg::t_opcode   opc;
    brr_pkg::t_funct3   f3;
    logic [XLEN-1:0]    op_a;
    logic [XLEN-1:0]    op_b;
    logic [XLEN-1:0]    pc;
    logic [XLEN-1:0]    imm_b;
    logic [XLEN-1:0]    imm_j;
    logic [XLEN-1:0]    imm_i;
    logic [XLEN-1:0]    pc_seq;
    logic [XLEN-1:0]    br_tgt;
    logic [XLEN-1:0]    jal_tgt;
    logic [XLEN-1:0]    jalr_sum;
    logic               eq;
    logic               lt_s;
    logic               lt_u;
    logic               br_taken;
    logic               br_ok;

    assign inst = i_req.instruction;
    assign opc  = inst[6:0];
    assign f3   = inst[14:12];
    assign pc   = i_req.pc_value[XLEN-1:0];

    brr_operand #(.XLEN(XLEN)) u_op_a (
        .i_src        (inst[19:15]),
        .i_file_value (i_req.rs1_file_value),
        .i_req        (i_req),
        .o_value      (op_a)
    );

    brr_operand #(.XLEN(XLEN)) u_op_b (
        .i_src        (inst[24:20]),
        .i_file_value (i_req.rs2_file_value),
        .i_req        (i_req),
        .o_value      (op_b)
    );

    assign imm_b = {{(XLEN-13){inst[31]}}, inst[31], inst[7], inst[30:25], inst[11:8], 1'b0};
    assign imm_j = {{(XLEN-21){inst[31]}}, inst[31], inst[19:12], inst[20], inst[30:21], 1'b0};
    assign imm_i = {{(XLEN-12){inst[31]}}, inst[31:20]};

    assign pc_seq   = pc + XLEN'(4);
    assign br_tgt   = pc + imm_b;
    assign jal_tgt  = pc + imm_j;
    assign jalr_sum = op_a + imm_i;

    assign eq   = (op_a == op_b);
    assign lt_s = ($signed(op_a) < $signed(op_b));
    assign lt_u = (op_a < op_b);

    always_comb begin
        br_ok = 1'b1;
        case (f3)
            brr_pkg::F3_BEQ:  br_taken = eq;
            brr_pkg::F3_BNE:  br_taken = !eq;
            brr_pkg::F3_BLT:  br_taken = lt_s;
            brr_pkg::F3_BGE:  br_taken = !lt_s;
            brr_pkg::F3_BLTU: br_taken = lt_u;
            brr_pkg::F3_BGEU: br_taken = !lt_u;
            default: begin
                br_taken = 1'b0;
                br_ok    = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_rsp = '0;
        case (opc)
            brr_pkg::OPC_BRANCH: begin
                o_rsp.is_control = 1'b1;
                if (br_ok) begin
                    o_rsp.resolved = 1'b1;
                    o_rsp.taken    = br_taken;
                    o_rsp.target   = brr_pkg::t_data'(br_taken ? br_tgt : pc_seq);
                end
            end
            brr_pkg::OPC_JAL: begin
                o_rsp.is_control = 1'b1;
                o_rsp.resolved   = 1'b1;
                o_rsp.taken      = 1'b1;
                o_rsp.target     = brr_pkg::t_data'(jal_tgt);
            end
            brr_pkg::OPC_JALR: begin
                o_rsp.is_control = 1'b1;
                if (f3 == brr_pkg::F3_JALR) begin
                    o_rsp.resolved = 1'b1;
                    o_rsp.taken    = 1'b1;
                    o_rsp.target   = brr_pkg::t_data'({jalr_sum[XLEN-1:1], 1'b0});
                end
            end
            default: o_rsp = '0;
        endcase
    end

endmodule

>>> sv/brr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brr_checker
// Port-level checks on the resolver result channel.
// ----------------------------------------------------------------------------
module brr_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          i_ready,
    input brr_pkg::t_rsp i_rsp
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_rsp))
        else $error("result changed while stalled");

    a_taken_resolved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_rsp.taken |-> i_rsp.resolved)
        else $error("taken without resolved");

    a_resolved_ctl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_rsp.resolved |-> i_rsp.is_control)
        else $error("resolved on non-control");

    a_unresolved_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_rsp.resolved |-> i_rsp.target == '0)
        else $error("unresolved result carries a target");

endmodule

bind riscv_branch_resolver brr_checker u_brr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_rsp.valid),
    .i_ready (o_rsp.ready),
    .i_rsp   (o_rsp.payload)
);
